// File: rtl/npf_pkg.sv
// package for the next prime finder: widths, wheel tables and sequencer states
`default_nettype none

package npf_pkg;

    // default search width
    localparam int NPF_WIDTH = 32;

    // port width of the value and result fields
    localparam int VAL_W = 32;

    // table sizes
    localparam int LOW_COUNT = 47;
    localparam int SPOKES    = 48;
    localparam int IDX_W     = 6;

    // wheel modulus and top of the prime table
    localparam int WHEEL     = 210;
    localparam int TABLE_TOP = 211;

    localparam logic [IDX_W-1:0] LAST_LOW   = IDX_W'(LOW_COUNT - 1);
    localparam logic [IDX_W-1:0] LAST_SPOKE = IDX_W'(SPOKES - 1);

    // primes up to the top of the table
    localparam logic [7:0] LOW_PRIMES [LOW_COUNT] = '{
          8'd2,   8'd3,   8'd5,   8'd7,  8'd11,  8'd13,  8'd17,  8'd19,  8'd23,  8'd29,
         8'd31,  8'd37,  8'd41,  8'd43,  8'd47,  8'd53,  8'd59,  8'd61,  8'd67,  8'd71,
         8'd73,  8'd79,  8'd83,  8'd89,  8'd97, 8'd101, 8'd103, 8'd107, 8'd109, 8'd113,
        8'd127, 8'd131, 8'd137, 8'd139, 8'd149, 8'd151, 8'd157, 8'd163, 8'd167, 8'd173,
        8'd179, 8'd181, 8'd191, 8'd193, 8'd197, 8'd199, 8'd211
    };

    // residues mod 210 coprime to 2, 3, 5 and 7
    localparam logic [7:0] WHEEL_RES [SPOKES] = '{
          8'd1,  8'd11,  8'd13,  8'd17,  8'd19,  8'd23,  8'd29,  8'd31,  8'd37,  8'd41,
         8'd43,  8'd47,  8'd53,  8'd59,  8'd61,  8'd67,  8'd71,  8'd73,  8'd79,  8'd83,
         8'd89,  8'd97, 8'd101, 8'd103, 8'd107, 8'd109, 8'd113, 8'd121, 8'd127, 8'd131,
        8'd137, 8'd139, 8'd143, 8'd149, 8'd151, 8'd157, 8'd163, 8'd167, 8'd169, 8'd173,
        8'd179, 8'd181, 8'd187, 8'd191, 8'd193, 8'd197, 8'd199, 8'd209
    };

    // gap from each residue to the next, cyclic
    localparam logic [3:0] WHEEL_GAP [SPOKES] = '{
        4'd10, 4'd2, 4'd4, 4'd2, 4'd4, 4'd6, 4'd2, 4'd6, 4'd4, 4'd2, 4'd4, 4'd6,
         4'd6, 4'd2, 4'd6, 4'd4, 4'd2, 4'd6, 4'd4, 4'd6, 4'd8, 4'd4, 4'd2, 4'd4,
         4'd2, 4'd4, 4'd8, 4'd6, 4'd4, 4'd6, 4'd2, 4'd4, 4'd6, 4'd2, 4'd6, 4'd6,
         4'd4, 4'd2, 4'd4, 4'd6, 4'd2, 4'd6, 4'd4, 4'd2, 4'd4, 4'd2, 4'd10, 4'd2
    };

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_TAB,
        S_MOD,
        S_MOD_WAIT,
        S_SPOKE,
        S_LOW,
        S_LOW_WAIT,
        S_WHL,
        S_WHL_WAIT,
        S_NEXT,
        S_DONE
    } state_t;

endpackage

`default_nettype wire

// File: rtl/npf_divider.sv
// restoring divider, one quotient bit per cycle, shared by all trial divisions
`default_nettype none

module npf_divider
    import npf_pkg::*;
#(
    parameter int WIDTH = NPF_WIDTH
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [WIDTH-1:0] dividend,
    input  wire logic [WIDTH-1:0] divisor,
    output logic                  busy,
    output logic                  done,
    output logic [WIDTH-1:0]      quotient,
    output logic [WIDTH-1:0]      remainder
);

    localparam int CNT_W = $clog2(WIDTH + 1);

    logic             run_reg, run_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [WIDTH-1:0] quot_reg, quot_next;
    logic [WIDTH-1:0] rem_reg, rem_next;
    logic [WIDTH-1:0] dvs_reg, dvs_next;
    logic [WIDTH:0]   trial;
    logic             fits;

    // one shift, compare and subtract step
    always_comb
    begin
        trial     = {rem_reg, quot_reg[WIDTH-1]};
        fits      = (trial >= {1'b0, dvs_reg});
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quot_next = quot_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start && !run_reg)
        begin
            run_next  = 1'b1;
            cnt_next  = CNT_W'(WIDTH);
            quot_next = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (run_reg)
        begin
            quot_next = {quot_reg[WIDTH-2:0], fits};
            rem_next  = fits ? WIDTH'(trial - {1'b0, dvs_reg}) : WIDTH'(trial);
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
    end

    assign busy      = run_reg;
    assign done      = done_reg;
    assign quotient  = quot_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

// File: rtl/next_prime_finder.sv
// next prime finder: table lookup, mod-210 wheel stepping and trial division
//
//  channel   signals                          direction  beat carries
//  in        in_valid / in_stall              to block   start_value
//  out       out_valid / out_stall            from block prime_out, overflow
//
// one beat in, one beat out; the block takes no new beat until the current one
// has moved into the output register. values below two go straight to the output,
// candidates up to 211 are found by scanning the prime table; the rest run one
// trial division on the shared divider for each divisor tried on each candidate
// (47 table primes, then up to ~sqrt(candidate)*48/210 wheel values).
// rst_n clears the sequencer, divider control and output valid; nothing else.
// a stalled result waits in the output register while the next beat is accepted.
`default_nettype none

module next_prime_finder
    import npf_pkg::*;
#(
    parameter int WIDTH = NPF_WIDTH
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire logic [VAL_W-1:0] start_value,
    output logic                  out_valid,
    input  wire logic             out_stall,
    output logic [VAL_W-1:0]      prime_out,
    output logic                  overflow
);

    state_t             state_reg, state_next;
    logic [WIDTH-1:0]   cand_reg, cand_next;
    logic [WIDTH-1:0]   d_reg, d_next;
    logic [IDX_W-1:0]   p_reg, p_next;
    logic [IDX_W-1:0]   m_reg, m_next;
    logic [IDX_W-1:0]   k_reg, k_next;
    logic [7:0]         x_reg, x_next;
    logic [WIDTH-1:0]   res_reg, res_next;
    logic               res_ovf_reg, res_ovf_next;
    logic               out_valid_reg, out_valid_next;
    logic [VAL_W-1:0]   prime_reg, prime_next;
    logic               ovf_reg, ovf_next;

    logic [WIDTH-1:0]   n_val;
    logic [WIDTH-1:0]   first_cand;
    logic [7:0]         step8;
    logic [WIDTH:0]     cand_sum;
    logic [WIDTH-1:0]   d_inc;
    logic               div_start;
    logic [WIDTH-1:0]   div_divisor;
    logic               div_busy;
    logic               div_done;
    logic [WIDTH-1:0]   div_quot;
    logic [WIDTH-1:0]   div_rem;

    // shared divider
    npf_divider #(
        .WIDTH (WIDTH)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (cand_reg),
        .divisor   (div_divisor),
        .busy      (div_busy),
        .done      (div_done),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    // sequencer next state and datapath updates
    always_comb
    begin
        n_val          = WIDTH'(start_value);
        first_cand     = (n_val + 1'b1) | WIDTH'(1);
        step8          = 8'(WHEEL_GAP[m_reg]);
        if (state_reg == S_SPOKE)
            step8 = WHEEL_RES[m_reg] - x_reg;
        cand_sum       = {1'b0, cand_reg} + (WIDTH+1)'(step8);
        d_inc          = d_reg + WIDTH'(WHEEL_GAP[k_reg]);

        state_next     = state_reg;
        cand_next      = cand_reg;
        d_next         = d_reg;
        p_next         = p_reg;
        m_next         = m_reg;
        k_next         = k_reg;
        x_next         = x_reg;
        res_next       = res_reg;
        res_ovf_next   = res_ovf_reg;
        out_valid_next = out_valid_reg && out_stall;
        prime_next     = prime_reg;
        ovf_next       = ovf_reg;
        div_start      = 1'b0;
        div_divisor    = WIDTH'(LOW_PRIMES[p_reg]);
        in_stall       = (state_reg != S_IDLE);

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (n_val < WIDTH'(2))
                    begin
                        res_next     = n_val;
                        res_ovf_next = 1'b0;
                        state_next   = S_DONE;
                    end
                    else if (&n_val)
                    begin
                        res_next     = '0;
                        res_ovf_next = 1'b1;
                        state_next   = S_DONE;
                    end
                    else
                    begin
                        cand_next  = first_cand;
                        p_next     = '0;
                        state_next = (first_cand <= WIDTH'(TABLE_TOP)) ? S_TAB : S_MOD;
                    end
                end
            end

            // small candidates: scan the prime table
            S_TAB:
            begin
                if (WIDTH'(LOW_PRIMES[p_reg]) >= cand_reg)
                begin
                    res_next     = WIDTH'(LOW_PRIMES[p_reg]);
                    res_ovf_next = 1'b0;
                    state_next   = S_DONE;
                end
                else
                begin
                    p_next = p_reg + 1'b1;
                end
            end

            // residue of the candidate on the wheel
            S_MOD:
            begin
                div_start   = 1'b1;
                div_divisor = WIDTH'(WHEEL);
                state_next  = S_MOD_WAIT;
            end

            S_MOD_WAIT:
            begin
                div_divisor = WIDTH'(WHEEL);
                if (div_done)
                begin
                    x_next     = div_rem[7:0];
                    m_next     = '0;
                    state_next = S_SPOKE;
                end
            end

            // find the first spoke at or above the residue, then move onto it
            S_SPOKE:
            begin
                if (m_reg != LAST_SPOKE && WHEEL_RES[m_reg] < x_reg)
                begin
                    m_next = m_reg + 1'b1;
                end
                else if (cand_sum[WIDTH])
                begin
                    res_next     = '0;
                    res_ovf_next = 1'b1;
                    state_next   = S_DONE;
                end
                else
                begin
                    cand_next  = cand_sum[WIDTH-1:0];
                    p_next     = '0;
                    state_next = S_LOW;
                end
            end

            // trial division by the table primes
            S_LOW:
            begin
                div_start  = 1'b1;
                state_next = S_LOW_WAIT;
            end

            S_LOW_WAIT:
            begin
                if (div_done)
                begin
                    if (div_rem == '0)
                    begin
                        state_next = S_NEXT;
                    end
                    else if (p_reg == LAST_LOW)
                    begin
                        d_next     = WIDTH'(TABLE_TOP);
                        k_next     = '0;
                        state_next = S_WHL;
                    end
                    else
                    begin
                        p_next     = p_reg + 1'b1;
                        state_next = S_LOW;
                    end
                end
            end

            // trial division by wheel values
            S_WHL:
            begin
                div_start   = 1'b1;
                div_divisor = d_inc;
                d_next      = d_inc;
                k_next      = (k_reg == LAST_SPOKE) ? '0 : k_reg + 1'b1;
                state_next  = S_WHL_WAIT;
            end

            S_WHL_WAIT:
            begin
                div_divisor = d_reg;
                if (div_done)
                begin
                    if (d_reg > div_quot)
                    begin
                        res_next     = cand_reg;
                        res_ovf_next = 1'b0;
                        state_next   = S_DONE;
                    end
                    else if (div_rem == '0)
                    begin
                        state_next = S_NEXT;
                    end
                    else
                    begin
                        state_next = S_WHL;
                    end
                end
            end

            // composite: step to the next spoke
            S_NEXT:
            begin
                m_next = (m_reg == LAST_SPOKE) ? '0 : m_reg + 1'b1;
                if (cand_sum[WIDTH])
                begin
                    res_next     = '0;
                    res_ovf_next = 1'b1;
                    state_next   = S_DONE;
                end
                else
                begin
                    cand_next  = cand_sum[WIDTH-1:0];
                    p_next     = '0;
                    state_next = S_LOW;
                end
            end

            // hand the result to the output register once it is free
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    prime_next     = VAL_W'(res_reg);
                    ovf_next       = res_ovf_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        cand_reg    <= cand_next;
        d_reg       <= d_next;
        p_reg       <= p_next;
        m_reg       <= m_next;
        k_reg       <= k_next;
        x_reg       <= x_next;
        res_reg     <= res_next;
        res_ovf_reg <= res_ovf_next;
        prime_reg   <= prime_next;
        ovf_reg     <= ovf_next;
    end

    assign out_valid = out_valid_reg;
    assign prime_out = prime_reg;
    assign overflow  = ovf_reg;

    // divider is only launched when it is free
    assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_busy)
        else $error("divider launched while busy");

    // an overflow result always carries zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && overflow) |-> (prime_out == '0))
        else $error("overflow result is not zero");

    // an accepted beat always starts work
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg != S_IDLE))
        else $error("accepted beat left the sequencer idle");

    // a finished result is moved out only when the output register can take it
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && out_valid_reg && out_stall) |=> (state_reg == S_DONE))
        else $error("result dropped while output was stalled");

endmodule

`default_nettype wire
